FILE: design/fhw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the fullwidth-to-halfwidth utf-8 converter
package fhw_pkg;

  // input and output transfer payloads
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } fhw_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_byte;
    logic       any_change;
  } fhw_out_t;

  // what the decoder hands to the window and encoder
  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_DIGIT = 2'd1,
    TOK_COLON = 2'd2,
    TOK_OTHER = 2'd3
  } tok_kind_t;

  // digit/colon window state
  typedef enum logic [1:0] {
    WIN_EMPTY = 2'd0,
    WIN_DIGIT = 2'd1,
    WIN_COLON = 2'd2
  } win_stage_t;

  // one decoded input byte, as queued between front and back
  typedef struct packed {
    logic [1:0]      pre_count;   // raw bytes of a broken sequence, window flushed first
    logic [2:0][7:0] pre_bytes;   // index 0 goes out first
    tok_kind_t       tok_kind;
    logic [3:0]      tok_digit;
    logic [2:0]      tok_count;   // 1 to 4 bytes for an other token
    logic [3:0][7:0] tok_bytes;
    logic            tok_change;  // code point was converted
    logic            post_valid;  // lead byte left open at end of text
    logic [7:0]      post_byte;
    logic            last;        // end of text
  } fhw_event_t;

  localparam int FHW_QUEUE_DEPTH = 4;
  localparam int FHW_QPTR_W      = $clog2(FHW_QUEUE_DEPTH);
  localparam int FHW_QCNT_W      = $clog2(FHW_QUEUE_DEPTH + 1);
  localparam int FHW_MAX_BYTES   = 8;
  localparam int FHW_IDX_W       = $clog2(FHW_MAX_BYTES);
  localparam int FHW_CNT_W       = $clog2(FHW_MAX_BYTES + 1);

  // code points
  localparam logic [20:0] CP_FW_DIGIT_LO = 21'h00FF10;
  localparam logic [20:0] CP_FW_DIGIT_HI = 21'h00FF19;
  localparam logic [20:0] CP_FW_UPPER_LO = 21'h00FF21;
  localparam logic [20:0] CP_FW_UPPER_HI = 21'h00FF3A;
  localparam logic [20:0] CP_FW_LOWER_LO = 21'h00FF41;
  localparam logic [20:0] CP_FW_LOWER_HI = 21'h00FF5A;
  localparam logic [20:0] CP_FW_OFFSET   = 21'h00FEE0;
  localparam logic [20:0] CP_IDEO_SPACE  = 21'h003000;
  localparam logic [20:0] CP_FW_COLON    = 21'h00FF1A;
  localparam logic [20:0] CP_MIN_2B      = 21'h000080;
  localparam logic [20:0] CP_MIN_3B      = 21'h000800;
  localparam logic [20:0] CP_MIN_4B      = 21'h010000;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;

  // bytes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] FW_COLON_B0 = 8'hEF;
  localparam logic [7:0] FW_COLON_B1 = 8'hBC;
  localparam logic [7:0] FW_COLON_B2 = 8'h9A;

endpackage

FILE: design/fhw_front.sv
`timescale 1ns / 1ps
// utf-8 decoder and classifier: one input byte in, one event out
module fhw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  fhw_pkg::fhw_in_t   item_data,
  input  logic               queue_full,
  output logic               ev_push,
  output fhw_pkg::fhw_event_t ev
);
  import fhw_pkg::*;

  // open sequence: bytes gathered so far and continuation bytes still expected
  logic [2:0][7:0] raw, raw_next;
  logic [1:0]      got, got_next;
  logic [1:0]      rem, rem_next;

  logic [7:0]  b;
  logic        eot;
  logic        xfer;
  logic [20:0] cp;
  logic [20:0] cp_conv;
  logic        cp_ok;
  logic [3:0][7:0] seq_bytes;

  assign b          = item_data.in_byte;
  assign eot        = item_data.end_of_text;
  assign item_stall = queue_full;
  assign xfer       = item_valid && !queue_full;
  assign ev_push    = xfer;
  assign cp_conv    = cp - CP_FW_OFFSET;

  // code point and validity of a sequence that completes with this byte
  always_comb begin
    case (got)
      2'd1: begin
        cp    = {10'd0, raw[0][4:0], b[5:0]};
        cp_ok = cp >= CP_MIN_2B;
      end
      2'd2: begin
        cp    = {5'd0, raw[0][3:0], raw[1][5:0], b[5:0]};
        cp_ok = cp >= CP_MIN_3B && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
      end
      2'd3: begin
        cp    = {raw[0][2:0], raw[1][5:0], raw[2][5:0], b[5:0]};
        cp_ok = cp >= CP_MIN_4B && cp <= CP_MAX;
      end
      default: begin
        cp    = 21'd0;
        cp_ok = 1'b0;
      end
    endcase
  end

  // original bytes of the completing sequence
  always_comb begin
    seq_bytes = {8'h00, raw[2], raw[1], raw[0]};
    seq_bytes[got] = b;
  end

  // decode and classify
  always_comb begin
    ev       = '0;
    raw_next = raw;
    got_next = got;
    rem_next = rem;
    ev.last  = eot;

    if (rem != 2'd0 && b[7:6] == 2'b10) begin
      if (rem > 2'd1) begin
        // continuation, more to come
        case (got)
          2'd1:    raw_next[1] = b;
          2'd2:    raw_next[2] = b;
          default: raw_next[0] = b;
        endcase
        got_next = got + 2'd1;
        rem_next = rem - 2'd1;
        if (eot) begin
          ev.pre_count = got + 2'd1;
          ev.pre_bytes = raw_next;
        end
      end else begin
        // sequence complete
        got_next     = 2'd0;
        rem_next     = 2'd0;
        ev.tok_kind  = TOK_OTHER;
        ev.tok_count = {1'b0, got} + 3'd1;
        ev.tok_bytes = seq_bytes;
        if (cp_ok) begin
          if (cp >= CP_FW_DIGIT_LO && cp <= CP_FW_DIGIT_HI) begin
            ev.tok_kind   = TOK_DIGIT;
            ev.tok_digit  = cp[3:0];
            ev.tok_change = 1'b1;
          end else if ((cp >= CP_FW_UPPER_LO && cp <= CP_FW_UPPER_HI) ||
                       (cp >= CP_FW_LOWER_LO && cp <= CP_FW_LOWER_HI)) begin
            ev.tok_count    = 3'd1;
            ev.tok_bytes    = '0;
            ev.tok_bytes[0] = cp_conv[7:0];
            ev.tok_change   = 1'b1;
          end else if (cp == CP_IDEO_SPACE) begin
            ev.tok_count    = 3'd1;
            ev.tok_bytes    = '0;
            ev.tok_bytes[0] = ASCII_SPACE;
            ev.tok_change   = 1'b1;
          end else if (cp == CP_FW_COLON) begin
            ev.tok_kind = TOK_COLON;
          end
        end
      end
    end else begin
      // broken sequence passes through raw
      if (rem != 2'd0) begin
        ev.pre_count = got;
        ev.pre_bytes = raw;
      end
      got_next = 2'd0;
      rem_next = 2'd0;
      if (!b[7]) begin
        if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
          ev.tok_kind  = TOK_DIGIT;
          ev.tok_digit = b[3:0];
        end else begin
          ev.tok_kind     = TOK_OTHER;
          ev.tok_count    = 3'd1;
          ev.tok_bytes[0] = b;
        end
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        // lead byte opens a sequence
        raw_next[0] = b;
        got_next    = 2'd1;
        if (b[7:5] == 3'b110) begin
          rem_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          rem_next = 2'd2;
        end else begin
          rem_next = 2'd3;
        end
        if (eot) begin
          ev.post_valid = 1'b1;
          ev.post_byte  = b;
        end
      end else begin
        // stray continuation or invalid lead
        ev.tok_kind     = TOK_OTHER;
        ev.tok_count    = 3'd1;
        ev.tok_bytes[0] = b;
      end
    end

    if (eot) begin
      got_next = 2'd0;
      rem_next = 2'd0;
    end
  end

  // decoder registers
  always_ff @(posedge clk) begin
    if (rst) begin
      got <= 2'd0;
      rem <= 2'd0;
    end else if (xfer) begin
      got <= got_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      raw <= raw_next;
    end
  end

endmodule

FILE: design/fhw_queue.sv
`timescale 1ns / 1ps
// small event queue between the decoder and the encoder
module fhw_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fhw_pkg::fhw_event_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output fhw_pkg::fhw_event_t head
);
  import fhw_pkg::*;

  fhw_event_t mem [FHW_QUEUE_DEPTH];
  logic [FHW_QPTR_W-1:0] wr_ptr;
  logic [FHW_QPTR_W-1:0] rd_ptr;
  logic [FHW_QCNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = count == FHW_QCNT_W'(FHW_QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FHW_QPTR_W'(FHW_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FHW_QPTR_W'(FHW_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/fhw_back.sv
`timescale 1ns / 1ps
// digit-colon window, utf-8 encoder and byte serializer
module fhw_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  fhw_pkg::fhw_event_t head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output fhw_pkg::fhw_out_t   result_data
);
  import fhw_pkg::*;

  typedef struct packed {
    logic [FHW_MAX_BYTES-1:0][7:0] bytes;
    logic [FHW_CNT_W-1:0]          count;
  } emit_t;

  function automatic emit_t push_byte(emit_t e, logic [7:0] nb);
    emit_t r;
    r = e;
    if (r.count < FHW_CNT_W'(FHW_MAX_BYTES)) begin
      r.bytes[r.count[FHW_IDX_W-1:0]] = nb;
      r.count = r.count + 1'b1;
    end
    return r;
  endfunction

  function automatic emit_t flush_win(emit_t e, win_stage_t st, logic [3:0] dg);
    emit_t r;
    r = e;
    if (st == WIN_DIGIT || st == WIN_COLON) begin
      r = push_byte(r, ASCII_ZERO | {4'h0, dg});
    end
    if (st == WIN_COLON) begin
      r = push_byte(r, FW_COLON_B0);
      r = push_byte(r, FW_COLON_B1);
      r = push_byte(r, FW_COLON_B2);
    end
    return r;
  endfunction

  win_stage_t stage, stage_next;
  logic [3:0] digit, digit_next;
  logic       change_seen, change_next;
  logic [FHW_IDX_W-1:0] idx;

  emit_t ex;
  logic  last_idx;
  logic  can_load;
  logic  load;

  // expand the head event into its output bytes
  always_comb begin
    ex          = '0;
    stage_next  = stage;
    digit_next  = digit;
    change_next = change_seen | head.tok_change;

    if (head.pre_count != 2'd0) begin
      ex         = flush_win(ex, stage_next, digit_next);
      stage_next = WIN_EMPTY;
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < head.pre_count) begin
          ex = push_byte(ex, head.pre_bytes[i]);
        end
      end
    end

    case (head.tok_kind)
      TOK_DIGIT: begin
        case (stage_next)
          WIN_DIGIT: begin
            ex         = push_byte(ex, ASCII_ZERO | {4'h0, digit_next});
            digit_next = head.tok_digit;
          end
          WIN_COLON: begin
            // digit colon digit: the colon goes halfwidth
            ex          = push_byte(ex, ASCII_ZERO | {4'h0, digit_next});
            ex          = push_byte(ex, ASCII_COLON);
            ex          = push_byte(ex, ASCII_ZERO | {4'h0, head.tok_digit});
            change_next = 1'b1;
            stage_next  = WIN_EMPTY;
          end
          default: begin
            digit_next = head.tok_digit;
            stage_next = WIN_DIGIT;
          end
        endcase
      end
      TOK_COLON: begin
        if (stage_next == WIN_DIGIT) begin
          stage_next = WIN_COLON;
        end else begin
          ex         = flush_win(ex, stage_next, digit_next);
          stage_next = WIN_EMPTY;
          ex         = push_byte(ex, FW_COLON_B0);
          ex         = push_byte(ex, FW_COLON_B1);
          ex         = push_byte(ex, FW_COLON_B2);
        end
      end
      TOK_OTHER: begin
        ex         = flush_win(ex, stage_next, digit_next);
        stage_next = WIN_EMPTY;
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < head.tok_count) begin
            ex = push_byte(ex, head.tok_bytes[i]);
          end
        end
      end
      default: begin
      end
    endcase

    if (head.post_valid) begin
      ex         = flush_win(ex, stage_next, digit_next);
      stage_next = WIN_EMPTY;
      ex         = push_byte(ex, head.post_byte);
    end

    if (head.last) begin
      ex         = flush_win(ex, stage_next, digit_next);
      stage_next = WIN_EMPTY;
    end
  end

  // serializer control
  assign last_idx = {1'b0, idx} == ex.count - 1'b1;
  assign can_load = !result_valid || !result_stall;
  assign load     = head_valid && ex.count != '0 && can_load;
  assign pop      = head_valid && (ex.count == '0 || (load && last_idx));

  // window and change state, committed when the event retires
  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= WIN_EMPTY;
      digit       <= 4'd0;
      change_seen <= 1'b0;
      idx         <= '0;
    end else begin
      if (pop) begin
        stage       <= head.last ? WIN_EMPTY : stage_next;
        digit       <= digit_next;
        change_seen <= head.last ? 1'b0 : change_next;
        idx         <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data.out_byte   <= ex.bytes[idx];
      result_data.final_byte <= head.last && last_idx;
      result_data.any_change <= head.last && last_idx && change_next;
    end
  end

endmodule

FILE: design/fullwidth_to_halfwidth_utf8_core.sv
`timescale 1ns / 1ps
// top level of the fullwidth-to-halfwidth utf-8 converter
//
// Takes UTF-8 text one byte per transfer and returns converted UTF-8 bytes:
// fullwidth digits and letters become ASCII, the ideographic space becomes
// a space, and a fullwidth colon between two digits becomes ':'. Malformed
// input passes through unchanged. The last output byte of a text carries
// final_byte, and any_change on it tells whether anything was converted.
// An input byte is taken every cycle while the four-entry event queue has
// room; the encoder sends one output byte per cycle unless the output stalls,
// an input byte with no output bytes still holds the encoder while it retires,
// and a result byte passes the queue storage and then the output register.
// A digit or a digit and colon may be held back until the next input byte
// or the end of text decides them. No clearing pass after reset.
module fullwidth_to_halfwidth_utf8_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  fhw_pkg::fhw_in_t  item_data,
  output logic              result_valid,
  input  logic              result_stall,
  output fhw_pkg::fhw_out_t result_data
);
  import fhw_pkg::*;

  fhw_event_t ev;
  fhw_event_t head;
  logic       ev_push;
  logic       queue_full;
  logic       head_valid;
  logic       pop;

  // decoder
  fhw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .queue_full (queue_full),
    .ev_push    (ev_push),
    .ev         (ev)
  );

  // event queue
  fhw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  // window, encoder and serializer
  fhw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

FILE: tb/fullwidth_to_halfwidth_utf8_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the fullwidth-to-halfwidth utf-8 converter core
module fullwidth_to_halfwidth_utf8_core_tb;
  import fhw_pkg::*;

  // one input byte of stimulus; known rows carry their expected result inline
  typedef struct packed {
    logic [7:0] in_b;
    logic       eot;
    logic       known;
    logic       has_res;
    logic [7:0] res_b;
    logic       res_final;
    logic       res_chg;
  } text_byte_t;

  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 75;
  localparam int MAX_OUT    = 8;
  localparam int HOLD_CYC   = 60;
  localparam int DRAIN_CYC  = 20;

  // directed text: extremes, stray bytes, conversions, colon match, broken input
  localparam text_byte_t DIRECTED [DIR_ROWS] = '{
    {8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},  // lowest byte alone
    {8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},  // highest byte, stray
    {8'h80, 1'b1, 1'b1, 1'b1, 8'h80, 1'b1, 1'b0},  // stray continuation
    {8'hEF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // fullwidth 'A'
    {8'hBC, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'hA1, 1'b1, 1'b1, 1'b1, 8'h41, 1'b1, 1'b1},
    {8'hE3, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // ideographic space
    {8'h80, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h80, 1'b1, 1'b1, 1'b1, 8'h20, 1'b1, 1'b1},
    {8'h35, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // digit held in window
    {8'hEF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // fullwidth colon held
    {8'hBC, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h9A, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'hEF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // fullwidth '9' closes match
    {8'hBC, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h99, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h37, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // digit held again
    {8'hED, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // surrogate flushes the digit
    {8'hA0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'hE3, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // sequence broken by ascii
    {8'h41, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'hC0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // overlong nul
    {8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'hF0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}   // lead left open at end of text
  };

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  fhw_in_t   item_data;
  logic      result_valid;
  logic      result_stall;
  fhw_out_t  result_data;

  text_byte_t text_bytes[$];
  fhw_out_t   want_q[$];
  int         drv_idx;
  int         mon_idx;
  int         err_count;

  // converter state as the predictor sees it
  logic [20:0] seq_bits;
  logic [1:0]  seq_left;
  win_stage_t  win;
  logic [3:0]  held_digit;
  logic        text_changed;
  logic [7:0]  step_bytes[$];

  fullwidth_to_halfwidth_utf8_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // utf-8 bytes of a value in a sequence of len bytes, first byte at index 0
  function automatic logic [3:0][7:0] utf8_seq(logic [23:0] v, int len);
    logic [3:0][7:0] bs;
    logic [7:0]      hdr;
    logic [7:0]      msk;
    int              i;
    bs = '0;
    case (len)
      2:       begin hdr = 8'hC0; msk = 8'h1F; end
      3:       begin hdr = 8'hE0; msk = 8'h0F; end
      default: begin hdr = 8'hF0; msk = 8'h07; end
    endcase
    if (len <= 1) begin
      bs[0] = v[7:0];
    end else begin
      bs[0] = hdr | (8'(v >> (6 * (len - 1))) & msk);
      for (i = 1; i < len; i++)
        bs[i] = 8'h80 | (8'(v >> (6 * (len - 1 - i))) & 8'h3F);
    end
    return bs;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_state();
    seq_bits     = '0;
    seq_left     = '0;
    win          = WIN_EMPTY;
    held_digit   = '0;
    text_changed = 1'b0;
  endtask

  task automatic put_out(logic [7:0] b);
    if (step_bytes.size() < MAX_OUT)
      step_bytes.push_back(b);
  endtask

  task automatic put_seq(logic [20:0] v, int len);
    logic [3:0][7:0] bs;
    int              i;
    bs = utf8_seq({3'b0, v}, len);
    for (i = 0; i < len; i++)
      put_out(bs[i]);
  endtask

  // release whatever the digit/colon window holds, unchanged
  task automatic flush_win();
    if (win == WIN_DIGIT || win == WIN_COLON)
      put_out(ASCII_ZERO + 8'(held_digit));
    if (win == WIN_COLON)
      put_seq(CP_FW_COLON, 3);
    win = WIN_EMPTY;
  endtask

  task automatic take_tok(tok_kind_t kind, logic [20:0] v, int len);
    if (kind == TOK_DIGIT) begin
      case (win)
        WIN_DIGIT: begin
          put_out(ASCII_ZERO + 8'(held_digit));
          held_digit = v[3:0];
        end
        WIN_COLON: begin
          put_out(ASCII_ZERO + 8'(held_digit));
          put_out(ASCII_COLON);
          put_out(ASCII_ZERO + 8'(v[3:0]));
          text_changed = 1'b1;
          win = WIN_EMPTY;
        end
        default: begin
          held_digit = v[3:0];
          win = WIN_DIGIT;
        end
      endcase
    end else if (kind == TOK_COLON && win == WIN_DIGIT) begin
      win = WIN_COLON;
    end else begin
      flush_win();
      put_seq(v, len);
    end
  endtask

  // width conversion, then classify for the window
  task automatic take_cp(logic [20:0] cp);
    logic [20:0] c;
    int          len;
    c = cp;
    if ((cp >= CP_FW_DIGIT_LO && cp <= CP_FW_DIGIT_HI) ||
        (cp >= CP_FW_UPPER_LO && cp <= CP_FW_UPPER_HI) ||
        (cp >= CP_FW_LOWER_LO && cp <= CP_FW_LOWER_HI)) begin
      c = cp - CP_FW_OFFSET;
      text_changed = 1'b1;
    end else if (cp == CP_IDEO_SPACE) begin
      c = 21'(ASCII_SPACE);
      text_changed = 1'b1;
    end
    if (c >= 21'(ASCII_ZERO) && c <= 21'(ASCII_NINE)) begin
      take_tok(TOK_DIGIT, c - 21'(ASCII_ZERO), 1);
    end else if (c == CP_FW_COLON) begin
      take_tok(TOK_COLON, c, 3);
    end else begin
      len = c < CP_MIN_2B ? 1 : (c < CP_MIN_3B ? 2 : (c < CP_MIN_4B ? 3 : 4));
      take_tok(TOK_OTHER, c, len);
    end
  endtask

  // pass the bytes of an open sequence through as they came
  task automatic flush_open();
    logic [3:0][7:0] bs;
    int              r;
    int              c;
    int              len;
    int              i;
    bit              found;
    r = seq_left;
    found = 1'b0;
    if (r > 0) begin
      for (c = 1; c <= 3 && !found; c++) begin
        len = c + r;
        if (len >= 2 && len <= 4 && (seq_bits >> (7 - len + 6 * (c - 1))) == 21'd1) begin
          found = 1'b1;
          flush_win();
          bs = utf8_seq({3'b0, seq_bits} << (6 * r), len);
          for (i = 0; i < c; i++)
            put_out(bs[i]);
        end
      end
    end
    seq_bits = '0;
    seq_left = '0;
  endtask

  // bytes the converter sends for one input transfer
  task automatic predict_step(fhw_in_t it, output fhw_out_t res[$]);
    logic [7:0]  b;
    logic [21:0] full;
    logic [20:0] cp;
    int          len;
    int          h;
    bit          ok;
    bit          last;
    int          i;
    b = it.in_byte;
    step_bytes.delete();
    res.delete();
    if (seq_left > 0 && b[7:6] == 2'b10) begin
      full = (22'(seq_bits) << 6) | 22'(b[5:0]);
      if (seq_left > 1) begin
        seq_bits = full[20:0];
        seq_left = seq_left - 2'd1;
      end else begin
        if (full[21]) begin
          len = 4; h = 21;
        end else if (full[16]) begin
          len = 3; h = 16;
        end else begin
          len = 2; h = 11;
        end
        cp = 21'(full & ((22'd1 << h) - 22'd1));
        case (len)
          2:       ok = cp >= CP_MIN_2B;
          3:       ok = cp >= CP_MIN_3B && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
          default: ok = cp >= CP_MIN_4B && cp <= CP_MAX;
        endcase
        seq_bits = '0;
        seq_left = '0;
        if (ok)
          take_cp(cp);
        else
          take_tok(TOK_OTHER, cp, len);
      end
    end else begin
      if (seq_left > 0)
        flush_open();
      if (b < 8'h80) begin
        take_cp(21'(b));
      end else if (b >= 8'hC0 && b <= 8'hDF) begin
        seq_bits = 21'h20 | 21'(b & 8'h1F);
        seq_left = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        seq_bits = 21'h10 | 21'(b & 8'h0F);
        seq_left = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF7) begin
        seq_bits = 21'h08 | 21'(b & 8'h07);
        seq_left = 2'd3;
      end else begin
        take_tok(TOK_OTHER, 21'(b), 1);
      end
    end
    if (it.end_of_text) begin
      flush_open();
      flush_win();
    end
    for (i = 0; i < step_bytes.size(); i++) begin
      last = it.end_of_text && (i == step_bytes.size() - 1);
      res.push_back({step_bytes[i], last, last & text_changed});
    end
    if (it.end_of_text)
      clear_state();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b);
    text_bytes.push_back({b, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
  endtask

  task automatic push_cp(logic [20:0] cp, int len, int count);
    logic [3:0][7:0] bs;
    int              i;
    bs = utf8_seq({3'b0, cp}, len);
    for (i = 0; i < count; i++)
      push_byte(bs[i]);
  endtask

  function automatic logic [20:0] valid_cp(int len);
    logic [20:0] cp;
    case (len)
      2: cp = 21'($urandom_range(32'h80, 32'h7FF));
      3: begin
        cp = 21'($urandom_range(32'h800, 32'hFFFF));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
          cp = 21'h00E000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  // malformed input of several kinds
  task automatic push_noise();
    int len;
    len = $urandom_range(2, 4);
    case ($urandom_range(0, 5))
      0: push_byte(8'($urandom_range(0, 255)));
      1: push_byte(8'($urandom_range(8'h80, 8'hBF)));
      2: push_cp(valid_cp(len), len, $urandom_range(1, len - 1));
      3: push_cp(21'($urandom_range(0, (1 << (5 * len - 4)) - 1)), len, len);
      4: push_cp(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3, 3);
      default: push_cp(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4, 4);
    endcase
  endtask

  // one text of random tokens, weighted toward digits and colons
  task automatic push_text();
    int ntok;
    int pick;
    int len;
    ntok = $urandom_range(1, 10);
    repeat (ntok) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        push_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
      end else if (pick < 40) begin
        push_cp(CP_FW_DIGIT_LO + 21'($urandom_range(0, 9)), 3, 3);
      end else if (pick < 55) begin
        push_cp(CP_FW_COLON, 3, 3);
      end else if (pick < 58) begin
        push_byte(ASCII_COLON);
      end else if (pick < 66) begin
        // fullwidth block from FF00 to FF5F, edges of the letter ranges included
        push_cp(21'($urandom_range(32'hFF00, 32'hFF5F)), 3, 3);
      end else if (pick < 69) begin
        push_cp(21'($urandom_range(CP_IDEO_SPACE - 1, CP_IDEO_SPACE + 1)), 3, 3);
      end else if (pick < 76) begin
        push_byte(8'($urandom_range(0, 8'h7F)));
      end else if (pick < 85) begin
        len = $urandom_range(2, 4);
        push_cp(valid_cp(len), len, len);
      end else begin
        push_noise();
      end
    end
    text_bytes[text_bytes.size() - 1].eot = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    drv_idx = 0;
    mon_idx = 0;
    err_count = 0;
    clear_state();
    foreach (DIRECTED[i])
      text_bytes.push_back(DIRECTED[i]);
    while (text_bytes.size() < DIR_ROWS + RAND_ITEMS)
      push_text();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (mon_idx < text_bytes.size() || want_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender: bursts of transfers with random gaps
  initial begin
    int unsigned burst;
    int unsigned gap;
    item_valid = 1'b0;
    item_data = '0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (drv_idx < text_bytes.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && drv_idx < text_bytes.size()) begin
        @(negedge clk);
        item_valid <= 1'b1;
        item_data <= {text_bytes[drv_idx].in_b, text_bytes[drv_idx].eot};
        @(posedge clk);
        while (item_stall) @(posedge clk);
        drv_idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    item_valid <= 1'b0;
  end

  // receiver: stall modes in random stretches, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned hold_left;
    bit          hold_done;
    result_stall = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && mon_idx >= DIR_ROWS + 20) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 40);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  // predict on each input transfer, check each output transfer in order
  always @(posedge clk) begin
    text_byte_t row;
    fhw_out_t   step_res[$];
    fhw_out_t   want;
    if (!rst && item_valid && !item_stall) begin
      row = text_bytes[mon_idx];
      mon_idx++;
      predict_step({row.in_b, row.eot}, step_res);
      if (row.known) begin
        if (row.has_res)
          want_q.push_back({row.res_b, row.res_final, row.res_chg});
      end else begin
        foreach (step_res[i])
          want_q.push_back(step_res[i]);
      end
    end
    if (!rst && result_valid && !result_stall) begin
      if (want_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transfer: got byte %02h final %0b change %0b", $time,
                 result_data.out_byte, result_data.final_byte, result_data.any_change);
      end else begin
        want = want_q.pop_front();
        if (result_data !== want) begin
          err_count++;
          $display({"%0t: mismatch: expected byte %02h final %0b change %0b, ",
                    "got byte %02h final %0b change %0b"}, $time,
                   want.out_byte, want.final_byte, want.any_change,
                   result_data.out_byte, result_data.final_byte, result_data.any_change);
        end
      end
    end
  end

endmodule
